### rtl/swrd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the short window repeat decoder
package swrd_pkg;

    // history window geometry
    localparam int C_WINDOW  = 32;
    localparam int C_PTR_W   = $clog2(C_WINDOW);
    localparam int C_FILL_W  = C_PTR_W + 1;

    // code byte that announces a literal
    localparam logic [7:0] C_ESCAPE = 8'hFF;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

endpackage

### rtl/short_window_repeat_decoder_core.sv
`timescale 1ns / 1ps
// short window repeat decoder: 32-byte history, escape literals and back copies
//
// Takes one compressed byte per input transfer and gives decoded bytes, one per
// output transfer. An escape byte gives no byte (or one error byte at chunk
// end); a literal gives one byte. A copy code of N bytes (1 to 8) first reads the
// history memory, then gives one byte per cycle while the output is not stalled,
// each read of the history memory (one write and one read port) overlapping the
// emit of the byte before it.
// A new input is taken only once the current one has put out all of its bytes.
// The history is not swept on reset or chunk end: a fill count marks which bytes
// are valid, and bytes beyond it read as zero.
module short_window_repeat_decoder_core
    import swrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // compressed input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_code_byte,
    input  logic       i_chunk_end,
    // decoded output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_chunk_last,
    output logic       o_trunc_error
);

    // control state
    t_state                r_state, n_state;
    logic [C_PTR_W-1:0]    r_wp, n_wp;
    logic [C_FILL_W-1:0]   r_fill, n_fill;
    logic                  r_esc, n_esc;
    logic [C_FILL_W-1:0]   r_dist, n_dist;
    logic [2:0]            r_left, n_left;
    logic [2:0]            r_step, n_step;
    logic                  r_last, n_last;

    // output register
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_run_last;
    logic                  r_chunk_last;
    logic                  r_trunc_error;

    // history memory and recent bytes of the running copy
    logic [7:0]            r_mem [C_WINDOW];
    logic [7:0]            r_rdata;
    logic [7:0]            r_recent [8];

    logic                  w_accept;
    logic                  w_out_free;
    logic [2:0]            w_tap;
    logic [7:0]            w_copy_byte;
    logic [C_PTR_W-1:0]    w_raddr;
    logic                  w_load;
    logic [7:0]            w_ld_byte;
    logic                  w_ld_run;
    logic                  w_ld_chunk;
    logic                  w_ld_err;
    logic                  w_we;
    logic [7:0]            w_wbyte;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // copy byte: zero before chunk start, from this copy when it overlaps, else memory
    assign w_tap = 3'(r_dist[2:0] - 3'd1);
    always_comb begin
        if (r_dist > r_fill) begin
            w_copy_byte = 8'd0;
        end else if (r_dist <= {{(C_FILL_W-3){1'b0}}, r_step}) begin
            w_copy_byte = r_recent[w_tap];
        end else begin
            w_copy_byte = r_rdata;
        end
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_esc      = r_esc;
        n_dist     = r_dist;
        n_left     = r_left;
        n_step     = r_step;
        n_last     = r_last;
        w_load     = 1'b0;
        w_ld_byte  = 8'd0;
        w_ld_run   = 1'b0;
        w_ld_chunk = 1'b0;
        w_ld_err   = 1'b0;
        w_we       = 1'b0;
        w_wbyte    = 8'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_esc) begin
                        // literal after escape
                        n_esc      = 1'b0;
                        w_load     = 1'b1;
                        w_ld_byte  = i_code_byte;
                        w_ld_run   = 1'b1;
                        w_ld_chunk = i_chunk_end;
                        w_we       = 1'b1;
                        w_wbyte    = i_code_byte;
                        n_wp       = C_PTR_W'(r_wp + 1'b1);
                        if (r_fill != C_FILL_W'(C_WINDOW)) begin
                            n_fill = C_FILL_W'(r_fill + 1'b1);
                        end
                        if (i_chunk_end) begin
                            n_wp   = '0;
                            n_fill = '0;
                        end
                    end else if (i_code_byte == C_ESCAPE) begin
                        if (i_chunk_end) begin
                            // escape with no literal left in the chunk
                            w_load     = 1'b1;
                            w_ld_run   = 1'b1;
                            w_ld_chunk = 1'b1;
                            w_ld_err   = 1'b1;
                            n_wp       = '0;
                            n_fill     = '0;
                        end else begin
                            n_esc = 1'b1;
                        end
                    end else begin
                        // start a back copy
                        n_state = ST_COPY;
                        n_dist  = C_FILL_W'(C_WINDOW) - {1'b0, i_code_byte[7:3]};
                        n_left  = i_code_byte[2:0];
                        n_step  = 3'd0;
                        n_last  = i_chunk_end;
                    end
                end
            end
            ST_COPY: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_ld_byte  = w_copy_byte;
                    w_ld_run   = (r_left == 3'd0);
                    w_ld_chunk = (r_left == 3'd0) && r_last;
                    w_we       = 1'b1;
                    w_wbyte    = w_copy_byte;
                    n_wp       = C_PTR_W'(r_wp + 1'b1);
                    if (r_fill != C_FILL_W'(C_WINDOW)) begin
                        n_fill = C_FILL_W'(r_fill + 1'b1);
                    end
                    if (r_left == 3'd0) begin
                        n_state = ST_IDLE;
                        if (r_last) begin
                            n_wp   = '0;
                            n_fill = '0;
                        end
                    end else begin
                        n_left = 3'(r_left - 3'd1);
                        n_step = 3'(r_step + 3'd1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read address for the next copy byte, registered into r_rdata
    assign w_raddr = C_PTR_W'(n_wp - n_dist[C_PTR_W-1:0]);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_esc   <= 1'b0;
            r_dist  <= '0;
            r_left  <= '0;
            r_step  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_esc   <= n_esc;
            r_dist  <= n_dist;
            r_left  <= n_left;
            r_step  <= n_step;
            r_last  <= n_last;
        end
    end

    // history memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wp] <= w_wbyte;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // recent decoded bytes, newest at index zero
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_recent[0] <= w_wbyte;
            for (int k = 1; k < 8; k++) begin
                r_recent[k] <= r_recent[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte    <= w_ld_byte;
            r_run_last    <= w_ld_run;
            r_chunk_last  <= w_ld_chunk;
            r_trunc_error <= w_ld_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_chunk_last  = r_chunk_last;
    assign o_trunc_error = r_trunc_error;

    // fill count never passes the window
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= C_FILL_W'(C_WINDOW))
        else $error("history fill beyond window");

    // write pointer tracks fill until the window is full
    a_wp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < C_FILL_W'(C_WINDOW)) |-> (r_wp == r_fill[C_PTR_W-1:0]))
        else $error("write pointer out of step with fill");

    // copy distance stays within the window
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_dist != '0 && r_dist <= C_FILL_W'(C_WINDOW)))
        else $error("copy distance out of range");

    // chunk end returns the history to empty
    a_chunk_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_ld_chunk) |=> (r_fill == '0 && r_wp == '0 && !r_esc))
        else $error("state not cleared after chunk end");

endmodule
